// ----- hdl/qsq_pkg.sv -----
// Shared constants, status codes and latency helpers for the quad-to-square map.
`default_nettype none
package qsq_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_BITS       = 21;
  localparam int STAT_BITS      = 2;
  localparam int CFG_IDX_BITS   = 3;
  localparam int MUL_DIG        = 16;
  localparam int CORNER_SIDE    = 256;
  localparam int REG_COUNT      = 8;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_DEGEN    = 2'd1,
    STAT_ZERO_DEN = 2'd2
  } map_stat_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_C00X, REG_C00Y, REG_C10X, REG_C10Y, REG_C11X, REG_C11Y, REG_C01X, REG_C01Y
  } reg_idx_t;

  // Cycles through qsq_mul for a multiplier operand of bw bits.
  function automatic int mul_lat(input int bw);
    return (bw + MUL_DIG - 1) / MUL_DIG + 2;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/qsq_mul.sv -----
// Pipelined signed multiplier, one MUL_DIG-bit digit of b per stage.
`default_nettype none
module qsq_mul
  import qsq_pkg::*;
#(
  parameter int AW = 35,
  parameter int BW = 35
) (
  input  wire logic                 clk,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int ND  = (BW + MUL_DIG - 1) / MUL_DIG;
  localparam int BPW = ND * MUL_DIG;
  localparam int EW  = AW + BPW;

  logic [AW-1:0]  ua_r  [0:ND];
  logic [BPW-1:0] ub_r  [0:ND];
  logic           neg_r [0:ND];
  logic [EW-1:0]  acc_r [0:ND];
  logic signed [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    ua_r[0]  <= a[AW-1] ? AW'(-a) : AW'(a);
    ub_r[0]  <= b[BW-1] ? BPW'(BW'(-b)) : BPW'(BW'(b));
    neg_r[0] <= a[AW-1] ^ b[BW-1];
    acc_r[0] <= '0;
  end

  for (genvar j = 1; j <= ND; j++) begin : g_dig
    logic [AW+MUL_DIG-1:0] pp;
    assign pp = ua_r[j-1] * ub_r[j-1][(j-1)*MUL_DIG +: MUL_DIG];
    always_ff @(posedge clk) begin
      ua_r[j]  <= ua_r[j-1];
      ub_r[j]  <= ub_r[j-1];
      neg_r[j] <= neg_r[j-1];
      acc_r[j] <= acc_r[j-1] + (EW'(pp) << ((j-1)*MUL_DIG));
    end
  end

  always_ff @(posedge clk) begin
    p_r <= neg_r[ND] ? (AW+BW)'(-acc_r[ND]) : (AW+BW)'(acc_r[ND]);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- hdl/qsq_coef.sv -----
// Map coefficients from the four corners, recomputed continuously.
`default_nettype none
module qsq_coef
  import qsq_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic signed [CW-1:0]       c00x,
  input  wire logic signed [CW-1:0]       c00y,
  input  wire logic signed [CW-1:0]       c10x,
  input  wire logic signed [CW-1:0]       c10y,
  input  wire logic signed [CW-1:0]       c11x,
  input  wire logic signed [CW-1:0]       c11y,
  input  wire logic signed [CW-1:0]       c01x,
  input  wire logic signed [CW-1:0]       c01y,
  output logic signed [CW-1:0]            ox,
  output logic signed [CW-1:0]            oy,
  output logic signed [CW:0]              ex,
  output logic signed [CW:0]              ey,
  output logic signed [CW:0]              fx,
  output logic signed [CW:0]              fy,
  output logic signed [3*(2*CW+3)+3:0]    a_co,
  output logic signed [2*(2*CW+3)+1:0]    b_co,
  output logic signed [2*(2*CW+3)+1:0]    c_co,
  output logic signed [2*(2*CW+3)+1:0]    ku_co,
  output logic signed [2*(2*CW+3)+1:0]    kv_co,
  output logic                            degen
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 3;
  localparam int KW = 2 * PW + 2;
  localparam int NW = 3 * PW + 4;

  logic signed [CW-1:0] ox_r, oy_r;
  logic signed [DW-1:0] ex_r, ey_r, fx_r, fy_r, cx_r, cy_r;
  logic signed [PW-1:0] det_r, ca_r, cb_r, det_nxt, ca_nxt, cb_nxt;
  logic signed [PW-1:0] det3_r, ca3_r, cb3_r;
  logic signed [PW:0]   cbd_r, cad_r;
  logic signed [PW+1:0] k_r;
  logic                 degen_r;
  logic signed [2*PW:0]   mb_p, mc_p;
  logic signed [2*PW+1:0] mku_p, mkv_p;
  logic signed [2*PW-1:0] mab_p;
  logic signed [3*PW-1:0] ma_p;

  always_ff @(posedge clk) begin
    ox_r <= c00x;
    oy_r <= c00y;
    ex_r <= DW'(c10x) - DW'(c00x);
    ey_r <= DW'(c10y) - DW'(c00y);
    fx_r <= DW'(c01x) - DW'(c00x);
    fy_r <= DW'(c01y) - DW'(c00y);
    cx_r <= DW'(c11x) - DW'(c00x);
    cy_r <= DW'(c11y) - DW'(c00y);
  end

  assign det_nxt = ex_r * fy_r - ey_r * fx_r;
  assign ca_nxt  = cx_r * fy_r - cy_r * fx_r;
  assign cb_nxt  = ex_r * cy_r - ey_r * cx_r;

  always_ff @(posedge clk) begin
    det_r   <= det_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    det3_r  <= det_r;
    ca3_r   <= ca_r;
    cb3_r   <= cb_r;
    cbd_r   <= (PW+1)'(cb_r) - (PW+1)'(det_r);
    cad_r   <= (PW+1)'(ca_r) - (PW+1)'(det_r);
    k_r     <= (PW+2)'(ca_r) + (PW+2)'(cb_r) - (PW+2)'(det_r);
    degen_r <= (det_r == '0) || (ca_r == '0) || (cb_r == '0);
  end

  qsq_mul #(.AW(PW), .BW(PW+1)) u_mul_b  (.clk(clk), .a(cb3_r), .b(cbd_r), .p(mb_p));
  qsq_mul #(.AW(PW), .BW(PW+1)) u_mul_c  (.clk(clk), .a(ca3_r), .b(cad_r), .p(mc_p));
  qsq_mul #(.AW(PW), .BW(PW+2)) u_mul_ku (.clk(clk), .a(cb3_r), .b(k_r),   .p(mku_p));
  qsq_mul #(.AW(PW), .BW(PW+2)) u_mul_kv (.clk(clk), .a(ca3_r), .b(k_r),   .p(mkv_p));
  qsq_mul #(.AW(PW), .BW(PW))   u_mul_ab (.clk(clk), .a(ca3_r), .b(cb3_r), .p(mab_p));
  // product of all three cross terms; det is steady by the time this settles
  qsq_mul #(.AW(2*PW), .BW(PW)) u_mul_a  (.clk(clk), .a(mab_p), .b(det3_r), .p(ma_p));

  assign ox    = ox_r;
  assign oy    = oy_r;
  assign ex    = ex_r;
  assign ey    = ey_r;
  assign fx    = fx_r;
  assign fy    = fy_r;
  assign a_co  = NW'(ma_p);
  assign b_co  = KW'(mb_p);
  assign c_co  = KW'(mc_p);
  assign ku_co = mku_p;
  assign kv_co = mkv_p;
  assign degen = degen_r;

endmodule
`default_nettype wire

// ----- hdl/qsq_fix.sv -----
// Pipelined rounding divide to signed fixed point, one quotient bit per stage, saturated.
`default_nettype none
module qsq_fix
  import qsq_pkg::*;
#(
  parameter int NW   = 109,
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [NW-1:0] den,
  output logic signed [OUT_BITS-1:0] res
);

  localparam int XW = NW + FRAC + OUT_BITS + 3;
  localparam logic [OUT_BITS-1:0] LIM_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] LIM_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic [NW-1:0] an, ad;
  logic [XW-1:0] n0, d0;
  logic [XW-1:0]       r_r   [0:OUT_BITS];
  logic [XW-1:0]       d_r   [0:OUT_BITS];
  logic [OUT_BITS-1:0] q_r   [0:OUT_BITS];
  logic                neg_r [0:OUT_BITS];
  logic                ovf_r [0:OUT_BITS];
  logic [OUT_BITS-1:0] lim, mag;
  logic signed [OUT_BITS-1:0] res_r;

  assign an = num[NW-1] ? NW'(-num) : NW'(num);
  assign ad = den[NW-1] ? NW'(-den) : NW'(den);
  // round half away: (2*|n|*2^F + |d|) / (2*|d|)
  assign n0 = (XW'(an) << (FRAC + 1)) + XW'(ad);
  assign d0 = XW'(ad) << 1;

  always_ff @(posedge clk) begin
    r_r[0]   <= n0;
    d_r[0]   <= d0;
    q_r[0]   <= '0;
    neg_r[0] <= num[NW-1] ^ den[NW-1];
    ovf_r[0] <= n0 >= (d0 << OUT_BITS);
  end

  for (genvar j = 1; j <= OUT_BITS; j++) begin : g_bit
    logic [XW-1:0] t;
    logic          ge;
    assign t  = d_r[j-1] << (OUT_BITS - j);
    assign ge = r_r[j-1] >= t;
    always_ff @(posedge clk) begin
      r_r[j]   <= ge ? r_r[j-1] - t : r_r[j-1];
      d_r[j]   <= d_r[j-1];
      neg_r[j] <= neg_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
      q_r[j]   <= q_r[j-1] | (ge ? (OUT_BITS'(1) << (OUT_BITS - j)) : '0);
    end
  end

  assign lim = neg_r[OUT_BITS] ? LIM_NEG : LIM_POS;
  assign mag = (ovf_r[OUT_BITS] || (q_r[OUT_BITS] > lim)) ? lim : q_r[OUT_BITS];

  always_ff @(posedge clk) begin
    res_r <= neg_r[OUT_BITS] ? -mag : mag;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- hdl/quad_to_square_projective_map_top.sv -----
// Top level: config registers, per-point datapath and output strobe.
//
// Maps a point to unit-square coordinates (16 fraction bits, saturated) under the
// projective map that sends the four configured corners to the square corners.
// One point is accepted per cycle whenever busy is low; each result appears on
// the out_ ports for one cycle with out_valid, in order, and cannot be held
// off. The latency is set by the digit-serial multipliers and by the 21-stage
// divider, one quotient bit per stage. After reset and after every cfg write,
// busy stays high while the coefficient pipeline recomputes from the corners.
// Status 1 flags degenerate corners, status 2 a zero denominator; both give
// zero coordinates.
`default_nettype none
module quad_to_square_projective_map_top
  import qsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  output logic                              out_valid,
  output logic signed [OUT_BITS-1:0]        out_square_u,
  output logic signed [OUT_BITS-1:0]        out_square_v,
  output logic [STAT_BITS-1:0]              out_map_status,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_wdata
);

  localparam int CW     = COORD_BITS;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * CW + 3;
  localparam int KW     = 2 * PW + 2;
  localparam int NW     = 3 * PW + 4;
  localparam int LM     = mul_lat(PW);
  localparam int SETTLE = 3 + 2 * LM + 1;
  localparam int SW     = $clog2(SETTLE + 1);
  localparam int SD     = OUT_BITS + 2;
  localparam int LAT    = LM + OUT_BITS + 5;
  localparam logic signed [CW-1:0] SIDE = CW'(CORNER_SIDE);

  logic signed [CW-1:0] c00x_r, c00y_r, c10x_r, c10y_r, c11x_r, c11y_r, c01x_r, c01y_r;
  logic [SW-1:0]        settle_r;
  logic [LAT-1:0]       vld_r;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c00x_r <= '0;   c00y_r <= '0;
      c10x_r <= SIDE; c10y_r <= '0;
      c11x_r <= SIDE; c11y_r <= SIDE;
      c01x_r <= '0;   c01y_r <= SIDE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_C00X: c00x_r <= cfg_wdata;
        REG_C00Y: c00y_r <= cfg_wdata;
        REG_C10X: c10x_r <= cfg_wdata;
        REG_C10Y: c10y_r <= cfg_wdata;
        REG_C11X: c11x_r <= cfg_wdata;
        REG_C11Y: c11y_r <= cfg_wdata;
        REG_C01X: c01x_r <= cfg_wdata;
        REG_C01Y: c01y_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      settle_r <= SW'(SETTLE);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SW'(1);
    end
  end

  assign busy   = settle_r != '0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  logic signed [CW-1:0] ox, oy;
  logic signed [DW-1:0] ex, ey, fx, fy;
  logic signed [NW-1:0] a_co;
  logic signed [KW-1:0] b_co, c_co, ku_co, kv_co;
  logic                 degen;

  qsq_coef #(.CW(CW)) u_coef (
    .clk(clk),
    .c00x(c00x_r), .c00y(c00y_r), .c10x(c10x_r), .c10y(c10y_r),
    .c11x(c11x_r), .c11y(c11y_r), .c01x(c01x_r), .c01y(c01y_r),
    .ox(ox), .oy(oy), .ex(ex), .ey(ey), .fx(fx), .fy(fy),
    .a_co(a_co), .b_co(b_co), .c_co(c_co), .ku_co(ku_co), .kv_co(kv_co),
    .degen(degen)
  );

  // point pipeline: translate, cross products, then digit-serial products
  logic signed [DW-1:0]    px_r, py_r;
  logic signed [PW-1:0]    ps_r, pt_r, ps_nxt, pt_nxt;
  logic signed [KW+PW-1:0] bps_p, cpt_p, nu_p, nv_p;
  logic signed [NW-1:0]    den_nxt, den_r, nu_r, nv_r;
  map_stat_t               st_nxt;
  map_stat_t               st_r [0:SD];

  always_ff @(posedge clk) begin
    px_r <= DW'(in_point_x) - DW'(ox);
    py_r <= DW'(in_point_y) - DW'(oy);
  end

  assign ps_nxt = px_r * fy - py_r * fx;
  assign pt_nxt = ex * py_r - ey * px_r;

  always_ff @(posedge clk) begin
    ps_r <= ps_nxt;
    pt_r <= pt_nxt;
  end

  qsq_mul #(.AW(KW), .BW(PW)) u_mul_bps (.clk(clk), .a(b_co),  .b(ps_r), .p(bps_p));
  qsq_mul #(.AW(KW), .BW(PW)) u_mul_cpt (.clk(clk), .a(c_co),  .b(pt_r), .p(cpt_p));
  qsq_mul #(.AW(KW), .BW(PW)) u_mul_nu  (.clk(clk), .a(ku_co), .b(ps_r), .p(nu_p));
  qsq_mul #(.AW(KW), .BW(PW)) u_mul_nv  (.clk(clk), .a(kv_co), .b(pt_r), .p(nv_p));

  assign den_nxt = a_co + NW'(bps_p) + NW'(cpt_p);

  always_comb begin
    priority if (degen) begin
      st_nxt = STAT_DEGEN;
    end else if (den_nxt == '0) begin
      st_nxt = STAT_ZERO_DEN;
    end else begin
      st_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    den_r    <= den_nxt;
    nu_r     <= NW'(nu_p);
    nv_r     <= NW'(nv_p);
    st_r[0]  <= st_nxt;
  end

  for (genvar i = 1; i <= SD; i++) begin : g_stat
    always_ff @(posedge clk) begin
      st_r[i] <= st_r[i-1];
    end
  end

  logic signed [OUT_BITS-1:0] u_q, v_q;

  qsq_fix #(.NW(NW), .FRAC(FRAC_BITS)) u_fix_u (.clk(clk), .num(nu_r), .den(den_r), .res(u_q));
  qsq_fix #(.NW(NW), .FRAC(FRAC_BITS)) u_fix_v (.clk(clk), .num(nv_r), .den(den_r), .res(v_q));

  assign out_valid      = vld_r[LAT-1];
  assign out_map_status = st_r[SD];
  assign out_square_u   = (st_r[SD] == STAT_OK) ? u_q : '0;
  assign out_square_v   = (st_r[SD] == STAT_OK) ? v_q : '0;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_map_status != STAT_OK) |-> (out_square_u == '0 && out_square_v == '0))
    else $error("nonzero coordinates on a failed transaction");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("transaction result missing at expected latency");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("not busy after a config write");

endmodule
`default_nettype wire
